// File: rtl/ira_pkg.sv
// Package: shared types and constants for the integer to radix ASCII converter.
package ira_pkg;

  localparam int unsigned ValueWidthDef = 32;

  localparam logic [5:0] RadixOct = 6'd8;
  localparam logic [5:0] RadixDec = 6'd10;
  localparam logic [5:0] RadixHex = 6'd16;

  localparam logic [6:0] ChrZero  = 7'h30;
  localparam logic [6:0] ChrLowA  = 7'h61;
  localparam logic [6:0] ChrX     = 7'h78;
  localparam logic [6:0] ChrMinus = 7'h2d;
  localparam logic [6:0] ChrNone  = 7'h00;

  typedef enum logic [1:0] {
    KIND_OCT = 2'd0,
    KIND_DEC = 2'd1,
    KIND_HEX = 2'd2,
    KIND_BAD = 2'd3
  } kind_e;

  function automatic logic [6:0] digit_chr(input logic [3:0] d);
    logic [6:0] r;
    if (d > 4'd9) begin
      r = ChrLowA + {3'd0, d} - 7'd10;
    end else begin
      r = ChrZero + {3'd0, d};
    end
    return r;
  endfunction

endpackage

// File: rtl/integer_to_radix_ascii_top.sv
// Top level: signed integer to octal, decimal or hex ASCII text converter.
//
//  channel | handshake                | payload
//  --------+--------------------------+-------------------------------------
//  in      | in_valid_i / in_ready_o  | value_i, radix_i
//  out     | out_valid_o / out_ready_i| character_o, last_char_o, bad_radix_o
//
// An item passes a magnitude stage and ValueWidth double-dabble stages
// (one bit each) before the serializer loads it. The serializer then emits
// one character per cycle while out_ready_i is high (1 to 13 per item
// at 32 bits), which sets the sustained rate; the pipeline behind it fills.
// Reset clears all valid bits; a stall on out holds each full stage that
// has no empty stage after it, while the others keep moving up.
module integer_to_radix_ascii_top #(
  parameter int unsigned ValueWidth = ira_pkg::ValueWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [ValueWidth-1:0] value_i,
  input  logic [5:0]                   radix_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [6:0]                   character_o,
  output logic                         last_char_o,
  output logic                         bad_radix_o
);
  import ira_pkg::*;

  localparam int unsigned DecDigits = (ValueWidth * 30103) / 100000 + 1;
  localparam int unsigned NumStages = ValueWidth + 1;

  typedef struct packed {
    logic [ValueWidth-1:0]  mag;
    logic                   neg;
    kind_e                  kind;
    logic [4*DecDigits-1:0] bcd;
  } item_t;

  item_t stage_q [NumStages];
  item_t stage_d [NumStages];
  logic  vld_q   [NumStages];
  logic  rdy     [NumStages+1];
  logic  ser_ready;

  always_comb begin
    stage_d[0].neg = value_i[ValueWidth-1];
    stage_d[0].mag = value_i[ValueWidth-1] ? (~value_i + 1'b1) : value_i;
    unique case (radix_i)
      RadixOct: stage_d[0].kind = KIND_OCT;
      RadixDec: stage_d[0].kind = KIND_DEC;
      RadixHex: stage_d[0].kind = KIND_HEX;
      default:  stage_d[0].kind = KIND_BAD;
    endcase
    stage_d[0].bcd = '0;
  end

  for (genvar k = 1; k < NumStages; k++) begin : g_dabble
    always_comb begin
      logic [4*DecDigits-1:0] adj;
      adj = stage_q[k-1].bcd;
      for (int d = 0; d < DecDigits; d++) begin
        if (adj[4*d +: 4] >= 4'd5) begin
          adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
        end
      end
      stage_d[k]      = stage_q[k-1];
      stage_d[k].bcd  = {adj[4*DecDigits-2:0], stage_q[k-1].mag[ValueWidth-k]};
    end
  end

  assign rdy[NumStages] = ser_ready;
  for (genvar k = 0; k < NumStages; k++) begin : g_pipe
    assign rdy[k] = !vld_q[k] | rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= (k == 0) ? in_valid_i : vld_q[k-1 < 0 ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  assign in_ready_o = rdy[0];

  ira_serializer #(
    .ValueWidth(ValueWidth)
  ) u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ld_valid_i (vld_q[NumStages-1]),
    .ld_ready_o (ser_ready),
    .ld_mag_i   (stage_q[NumStages-1].mag),
    .ld_neg_i   (stage_q[NumStages-1].neg),
    .ld_kind_i  (stage_q[NumStages-1].kind),
    .ld_bcd_i   (stage_q[NumStages-1].bcd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .character_o(character_o),
    .last_char_o(last_char_o),
    .bad_radix_o(bad_radix_o)
  );

endmodule

// File: rtl/ira_serializer.sv
// Serializer: holds one converted item and emits its characters one per transfer.
module ira_serializer #(
  parameter int unsigned ValueWidth = ira_pkg::ValueWidthDef
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      ld_valid_i,
  output logic                                      ld_ready_o,
  input  logic [ValueWidth-1:0]                     ld_mag_i,
  input  logic                                      ld_neg_i,
  input  ira_pkg::kind_e                            ld_kind_i,
  input  logic [4*((ValueWidth*30103)/100000+1)-1:0] ld_bcd_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [6:0]                                character_o,
  output logic                                      last_char_o,
  output logic                                      bad_radix_o
);
  import ira_pkg::*;

  localparam int unsigned NumDigits = (ValueWidth + 2) / 3;
  localparam int unsigned PadWidth  = 4 * NumDigits;
  localparam int unsigned IdxWidth  = (NumDigits > 1) ? $clog2(NumDigits) : 1;

  logic                busy_q, busy_d;
  logic                bad_q, bad_d;
  logic                sign_q, sign_d;
  logic                zero_q, zero_d;
  logic                x_q, x_d;
  logic [IdxWidth-1:0] pos_q, pos_d;
  logic [3:0]          dig_q [NumDigits];
  logic [3:0]          dig_d [NumDigits];
  logic [IdxWidth-1:0] msd;
  logic [PadWidth-1:0] mag_pad;
  logic [PadWidth-1:0] bcd_pad;
  logic                take;
  logic                load;

  assign mag_pad = PadWidth'(ld_mag_i);
  assign bcd_pad = PadWidth'(ld_bcd_i);

  always_comb begin
    msd = '0;
    for (int j = 0; j < NumDigits; j++) begin
      unique case (ld_kind_i)
        KIND_OCT: dig_d[j] = {1'b0, mag_pad[3*j +: 3]};
        KIND_HEX: dig_d[j] = mag_pad[4*j +: 4];
        KIND_DEC: dig_d[j] = bcd_pad[4*j +: 4];
        default:  dig_d[j] = 4'd0;
      endcase
      if (dig_d[j] != 4'd0) begin
        msd = IdxWidth'(j);
      end
    end
  end

  assign out_valid_o = busy_q;
  assign last_char_o = bad_q | (!sign_q && !zero_q && !x_q && pos_q == '0);
  assign bad_radix_o = bad_q;

  always_comb begin
    if (bad_q) begin
      character_o = ChrNone;
    end else if (sign_q) begin
      character_o = ChrMinus;
    end else if (zero_q) begin
      character_o = ChrZero;
    end else if (x_q) begin
      character_o = ChrX;
    end else begin
      character_o = digit_chr(dig_q[pos_q]);
    end
  end

  assign take       = busy_q & out_ready_i;
  assign ld_ready_o = !busy_q | (take & last_char_o);
  assign load       = ld_valid_i & ld_ready_o;

  always_comb begin
    busy_d = busy_q;
    bad_d  = bad_q;
    sign_d = sign_q;
    zero_d = zero_q;
    x_d    = x_q;
    pos_d  = pos_q;
    if (take) begin
      priority if (last_char_o) begin
        busy_d = 1'b0;
      end else if (sign_q) begin
        sign_d = 1'b0;
      end else if (zero_q) begin
        zero_d = 1'b0;
      end else if (x_q) begin
        x_d = 1'b0;
      end else begin
        pos_d = pos_q - 1'b1;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      bad_d  = (ld_kind_i == KIND_BAD);
      sign_d = ld_neg_i && (ld_kind_i != KIND_BAD);
      zero_d = (ld_kind_i == KIND_OCT) || (ld_kind_i == KIND_HEX);
      x_d    = (ld_kind_i == KIND_HEX);
      pos_d  = msd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bad_q  <= 1'b0;
      sign_q <= 1'b0;
      zero_q <= 1'b0;
      x_q    <= 1'b0;
      pos_q  <= '0;
    end else begin
      busy_q <= busy_d;
      bad_q  <= bad_d;
      sign_q <= sign_d;
      zero_q <= zero_d;
      x_q    <= x_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dig_q <= dig_d;
    end
  end

endmodule

// File: test/tb_top.sv
// Testbench for the integer to radix ASCII converter: directed and random items, text predicted.
module tb_top;
  import ira_pkg::*;

  localparam int unsigned VW = ValueWidthDef;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [6:0] chr;
    logic       last;
    logic       bad;
  } char_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic signed [VW-1:0] value_i = '0;
  logic [5:0]           radix_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [6:0]           character_o;
  logic                 last_char_o;
  logic                 bad_radix_o;

  char_t       text_q[$];
  int unsigned mismatches = 0;
  int unsigned chars_seen = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  int unsigned hold_off = 0;
  int unsigned rx_wait = 0;
  bit          rx_done = 1'b0;
  bit          rx_idle_on = 1'b1;
  bit          tx_idle_on = 1'b1;

  integer_to_radix_ascii_top #(.ValueWidth(VW)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .value_i, .radix_i,
    .out_valid_o, .out_ready_i, .character_o, .last_char_o, .bad_radix_o
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [6:0] to_digit(input logic [VW-1:0] d);
    return (d > 9) ? (ChrLowA + 7'(d) - 7'd10) : (ChrZero + 7'(d));
  endfunction

  // Expected text of one conversion
  task automatic predict_text(input logic [VW-1:0] val, input logic [5:0] rdx);
    logic [6:0]    txt[$];
    logic [6:0]    digs[$];
    logic [VW-1:0] mag;
    logic          neg;
    char_t         c;
    neg = val[VW-1];
    mag = neg ? (~val + 1'b1) : val;
    if (rdx != RadixOct && rdx != RadixDec && rdx != RadixHex) begin
      c = '{chr: ChrNone, last: 1'b1, bad: 1'b1};
      text_q.push_back(c);
      return;
    end
    do begin
      digs.push_front(to_digit(mag % VW'(rdx)));
      mag = mag / VW'(rdx);
    end while (mag != 0);
    if (neg) txt.push_back(ChrMinus);
    if (rdx == RadixOct) txt.push_back(ChrZero);
    if (rdx == RadixHex) begin
      txt.push_back(ChrZero);
      txt.push_back(ChrX);
    end
    foreach (digs[i]) txt.push_back(digs[i]);
    foreach (txt[i]) begin
      c = '{chr: txt[i], last: (i == txt.size() - 1), bad: 1'b0};
      text_q.push_back(c);
    end
  endtask

  // Called at a falling edge; valid stays high between back-to-back items
  task automatic send_item(input logic [VW-1:0] val, input logic [5:0] rdx);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i <= val;
    radix_i <= rdx;
    predict_text(val, rdx);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Receiver readiness: a fresh wait is drawn after each transfer
  always @(negedge clk_i) begin
    if (rx_done) begin
      rx_done = 1'b0;
      rx_wait = rx_idle_on ? $urandom_range(0, 7) : 0;
    end
    if (hold_off != 0) begin
      hold_off = hold_off - 1;
      out_ready_i <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait = rx_wait - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Check each transfer on the output side
  always @(posedge clk_i) begin
    char_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      rx_done = 1'b1;
      got = '{chr: character_o, last: last_char_o, bad: bad_radix_o};
      chars_seen++;
      if (text_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected char %h last %b bad %b",
                                       got.chr, got.last, got.bad);
      end else begin
        want = text_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp chr %h last %b bad %b, got chr %h last %b bad %b",
                     want.chr, want.last, want.bad, got.chr, got.last, got.bad);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_directed();
    logic [5:0] radixes[3];
    radixes = '{RadixOct, RadixDec, RadixHex};
    foreach (radixes[i]) begin
      send_item('0, radixes[i]);
      send_item({1'b1, {(VW-1){1'b0}}}, radixes[i]);
      send_item({1'b0, {(VW-1){1'b1}}}, radixes[i]);
      send_item('1, radixes[i]);
      send_item(VW'(9), radixes[i]);
      send_item(VW'(15), radixes[i]);
    end
    send_item(VW'(123), 6'd0);
    send_item(VW'(-5), 6'd63);
    send_item(VW'(77), 6'd2);
    send_item(VW'(77), 6'd9);
  endtask

  task automatic test_random(input int unsigned count);
    logic [VW-1:0] val;
    logic [5:0]    rdx;
    repeat (count) begin
      case ($urandom_range(0, 3))
        0: val = VW'($urandom_range(0, 20));
        1: val = -VW'($urandom_range(0, 20));
        default: val = VW'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: rdx = RadixOct;
        3, 4, 5: rdx = RadixDec;
        6, 7, 8: rdx = RadixHex;
        default: rdx = 6'($urandom_range(0, 63));
      endcase
      send_item(val, rdx);
    end
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    test_random(40);
  endtask

  task automatic test_streaming();
    rx_idle_on = 1'b0;
    tx_idle_on = 1'b0;
    test_random(60);
    rx_idle_on = 1'b1;
    tx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(300);
    test_backpressure();
    test_streaming();
    test_random(100);
    in_valid_i <= 1'b0;
    while (text_q.size() != 0) @(posedge clk_i);
    repeat (3 * VW + 40) @(posedge clk_i);
    $display("%0d items converted, %0d characters checked, radix 8/10/16 and invalid bases",
             items_sent, chars_seen);
    $display("covered extremes, zero, random values, output stalls and a long hold-off");
    if (mismatches == 0 && text_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
